>>> rtl/sfp16_pkg.sv
// Package for the SFP16 adder: encoding type, special values and widths.
// Used by the interfaces, the add core and the top level.
package sfp16_pkg;

  typedef logic [15:0] sfp16_t;

  localparam sfp16_t SFP_PINF = 16'h7F00;
  localparam sfp16_t SFP_NINF = 16'hFF00;
  localparam sfp16_t SFP_NAN  = 16'hFF01;

  localparam int unsigned EXP_W  = 7;
  localparam int unsigned FRAC_W = 8;
  localparam logic [EXP_W-1:0] EXP_MAX = 7'h7F;

  localparam int unsigned MAX_ALIGN = 11;

endpackage

>>> rtl/sfp16_in_if.sv
// Operand channel of the SFP16 adder: valid/ready and one operand pair per beat.
// Depends on sfp16_pkg.
interface sfp16_in_if import sfp16_pkg::*; ();
  logic   valid;
  logic   ready;
  sfp16_t operand_a;
  sfp16_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

>>> rtl/sfp16_out_if.sv
// Result channel of the SFP16 adder: valid/ready and one sum per beat.
// Depends on sfp16_pkg.
interface sfp16_out_if import sfp16_pkg::*; ();
  logic   valid;
  logic   ready;
  sfp16_t sum;

  modport source (output valid, output sum, input ready);
  modport sink (input valid, input sum, output ready);
endinterface

>>> rtl/sfp16_add_core.sv
// Combinational SFP16 add: specials, alignment with guard/round/sticky,
// add or subtract, normalize, round to nearest even. Depends on sfp16_pkg.
module sfp16_add_core import sfp16_pkg::*; (
  input  sfp16_t a,
  input  sfp16_t b,
  output sfp16_t sum
);

  logic               a_nan, b_nan, a_zero, b_zero, swap;
  sfp16_t             x, y;
  logic [EXP_W-1:0]   ex_x, ex_y, d;
  logic [3:0]         dsh;
  logic [8:0]         mx, my, mya;
  logic [19:0]        yw;
  logic               g, r, st, same, cancel;
  logic [12:0]        op_a, op_b, comb;
  logic [11:0]        norm;
  logic [3:0]         lz;
  logic [8:0]         mant;
  logic               rnd, stk, up;
  logic [9:0]         mant_up;
  logic [8:0]         mant_r;
  logic signed [8:0]  e_n, sh;
  logic [8:0]         sub_m;

  always_comb begin
    a_nan  = (a[14:8] == EXP_MAX) && (a[7:0] != '0);
    b_nan  = (b[14:8] == EXP_MAX) && (b[7:0] != '0);
    a_zero = (a[14:0] == '0);
    b_zero = (b[14:0] == '0);
    swap   = b[14:0] > a[14:0];
    x      = swap ? b : a;
    y      = swap ? a : b;
    ex_x   = (x[14:8] == '0) ? 7'd1 : x[14:8];
    ex_y   = (y[14:8] == '0) ? 7'd1 : y[14:8];
    mx     = {x[14:8] != '0, x[7:0]};
    my     = {y[14:8] != '0, y[7:0]};
    d      = ex_x - ex_y;
    dsh    = (d > 7'(MAX_ALIGN)) ? 4'(MAX_ALIGN) : d[3:0];
    yw     = {my, 11'b0} >> dsh;
    mya    = yw[19:11];
    g      = yw[10];
    r      = yw[9];
    st     = |yw[8:0];
    same   = x[15] == y[15];
    cancel = (ex_x == ex_y) && (mx == my) && !same;
    op_a   = {1'b0, mx, 3'b000};
    op_b   = {1'b0, mya, g, r, st};
    comb   = same ? (op_a + op_b) : (op_a - op_b);

    lz = '0;
    for (int i = 0; i < 12; i++) begin
      if (comb[i]) lz = 4'(11 - i);
    end
    norm = comb[11:0] << lz;

    if (comb[12]) begin
      mant = comb[12:4];
      rnd  = comb[3];
      stk  = |comb[2:0];
    end else begin
      mant = norm[11:3];
      rnd  = norm[2];
      stk  = norm[1] | norm[0];
    end
    up      = rnd && (stk || mant[0]);
    mant_up = {1'b0, mant} + {9'b0, up};
    mant_r  = mant_up[9] ? mant_up[9:1] : mant_up[8:0];

    e_n = $signed({2'b00, ex_x}) + $signed({8'b0, comb[12]})
        - (comb[12] ? 9'sd0 : $signed({5'b0, lz})) + $signed({8'b0, mant_up[9]});
    sh    = 9'sd1 - e_n;
    sub_m = (sh > 9'sd15) ? 9'd0 : (mant_r >> sh[3:0]);

    priority if (a_nan || b_nan) begin
      sum = SFP_NAN;
    end else if (a == SFP_PINF) begin
      sum = (b == SFP_NINF) ? SFP_NAN : SFP_PINF;
    end else if (a == SFP_NINF) begin
      sum = (b == SFP_PINF) ? SFP_NAN : SFP_NINF;
    end else if (b == SFP_PINF || b == SFP_NINF) begin
      sum = b;
    end else if (a_zero && b_zero) begin
      sum = {a[15] & b[15], 15'b0};
    end else if (a_zero) begin
      sum = b;
    end else if (cancel || comb == '0) begin
      sum = '0;
    end else if (e_n >= 9'sd127) begin
      sum = x[15] ? SFP_NINF : SFP_PINF;
    end else if (e_n <= 9'sd0) begin
      sum = {x[15], 7'b0, sub_m[7:0]};
    end else begin
      sum = {x[15], e_n[6:0], mant_r[7:0]};
    end
  end

endmodule

>>> rtl/sfp16_float_adder.sv
// Top level of the SFP16 adder: operand register, add core, result register.
// Depends on sfp16_pkg, sfp16_in_if, sfp16_out_if and sfp16_add_core.
//
// Usage:
//   in_ch  carries one operand pair (operand_a, operand_b) per beat.
//   out_ch carries one rounded sum per beat, NaN always as 0xFF01.
//   A beat moves when valid and ready are both high at a rising edge.
// Throughput: one beat per cycle unless out_ch stalls; the operand register feeds
//   the add core, whose single pass ends in the result register.
// Reset: rst_n low at a clock edge empties both registers; beats held in them
//   are dropped and none is shown afterward.
// Stall: while out_ch.ready is low and a sum waits, the result register
//   holds; the operand register still takes one more beat, then in_ch.ready
//   drops until the receiver takes the waiting sum.
module sfp16_float_adder import sfp16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sfp16_in_if.sink   in_ch,
  sfp16_out_if.source out_ch
);

  logic   s1_valid_r, out_valid_r, advance;
  sfp16_t s1_a_r, s1_b_r, out_sum_r, core_sum;

  sfp16_add_core u_core (
    .a   (s1_a_r),
    .b   (s1_b_r),
    .sum (core_sum)
  );

  assign advance       = !out_valid_r || out_ch.ready;
  assign in_ch.ready   = !s1_valid_r || advance;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sum    = out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_a_r <= in_ch.operand_a;
      s1_b_r <= in_ch.operand_b;
    end
    if (advance && s1_valid_r) out_sum_r <= core_sum;
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance |=> out_valid_r)
    else $error("operand beat lost on advance");

  a_nan_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance && s1_a_r[14:8] == EXP_MAX && s1_a_r[7:0] != '0
    |=> out_sum_r == SFP_NAN)
    else $error("NaN operand not propagated");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_a_r) && $stable(s1_b_r))
    else $error("operand register changed during stall");

endmodule

>>> dv/sfp16_float_adder_test.sv
// Testbench for the SFP16 adder: drives operand pairs over in_ch, checks sums on out_ch
// against a bit-accurate predictor kept in a small scoreboard class.
// Depends on sfp16_pkg, sfp16_in_if, sfp16_out_if and sfp16_float_adder.
module sfp16_float_adder_test;
  import sfp16_pkg::*;

  class sum_scoreboard;
    sfp16_t pending_sums[$];
    int errors;
    int checked;

    function sfp16_t add_sfp16(sfp16_t x, sfp16_t y);
      sfp16_t t;
      logic [9:0] ma, mb;
      logic g, r, st, sa, sb;
      logic [2:0] grs;
      int ea, eb, d, sh;
      logic [6:0] ex;
      g = 0;
      r = 0;
      st = 0;
      if ((x[14:8] == EXP_MAX && x[7:0] != 0) || (y[14:8] == EXP_MAX && y[7:0] != 0))
        return SFP_NAN;
      if (x == SFP_PINF) return (y == SFP_NINF) ? SFP_NAN : SFP_PINF;
      if (x == SFP_NINF) return (y == SFP_PINF) ? SFP_NAN : SFP_NINF;
      if (y == SFP_PINF || y == SFP_NINF) return y;
      if (x[14:0] == 0 && y[14:0] == 0) return (x & y) & 16'h8000;
      if (x[14:0] == 0) return y;
      if (y[14:0] > x[14:0]) begin
        t = x;
        x = y;
        y = t;
      end
      sa = x[15];
      sb = y[15];
      ma = {2'b0, x[7:0]};
      mb = {2'b0, y[7:0]};
      if (x[14:8] == 0) ea = -62;
      else begin
        ea = int'(x[14:8]) - 63;
        ma[8] = 1;
      end
      if (y[14:8] == 0) eb = -62;
      else begin
        eb = int'(y[14:8]) - 63;
        mb[8] = 1;
      end
      if (ea == eb && ma == mb && sa != sb) return 16'h0000;
      d = ea - eb;
      for (int i = 0; i < d; i++) begin
        st |= r;
        r = g;
        g = mb[0];
        mb >>= 1;
      end
      if (sa == sb) ma = ma + mb;
      else if ({g, r, st} == 0) ma = ma - mb;
      else begin
        grs = 3'd0 - {g, r, st};
        ma = ma - mb - 10'd1;
        {g, r, st} = grs;
      end
      if (ma == 0 && {g, r, st} == 0) return 16'h0000;
      while (ma < 10'h100) begin
        ma = {ma[8:0], g};
        g = r;
        r = st;
        st = 0;
        ea--;
      end
      while (ma > 10'h1FF) begin
        st |= r;
        r = g;
        g = ma[0];
        ma >>= 1;
        ea++;
      end
      st |= r;
      r = g;
      if (r && (st || ma[0])) ma++;
      while (ma > 10'h1FF) begin
        ma >>= 1;
        ea++;
      end
      if (ea >= 64) return sa ? SFP_NINF : SFP_PINF;
      if (ea <= -63) begin
        sh = -62 - ea;
        ma = (sh >= 16) ? 10'd0 : (ma >> sh);
        ea = -63;
      end
      ex = 7'(ea + 63);
      return {sa, ex, ma[7:0]};
    endfunction

    function void note_operands(sfp16_t a, sfp16_t b);
      pending_sums.push_back(add_sfp16(a, b));
    endfunction

    function void check_sum(sfp16_t got);
      sfp16_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum %h", $time, got);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: sum mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  sfp16_in_if in_ch();
  sfp16_out_if out_ch();
  sum_scoreboard board = new();
  bit long_hold = 0;
  bit send_done = 0;

  sfp16_float_adder dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #1 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic sfp16_t pick_operand();
    sfp16_t v;
    int p;
    v = sfp16_t'($urandom);
    p = $urandom_range(99);
    if (p < 10) v[14:8] = 0;
    else if (p < 18) v[14:8] = EXP_MAX;
    else if (p < 24) v[14:8] = EXP_MAX - 7'd1;
    else if (p < 28) v[14:0] = 0;
    else if (p < 32) v[7:0] = 0;
    return v;
  endfunction

  task automatic send_pair(sfp16_t a, sfp16_t b, bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_operands(a, b);
  endtask

  initial begin
    sfp16_t a, b;
    sfp16_t dir_ops[24] = '{
      16'h0000, 16'h8000, 16'h7F00, 16'hFF00, 16'h7F01, 16'hFF11, 16'h7EFF, 16'hFEFF,
      16'h0001, 16'h80FF, 16'h0100, 16'h3F00, 16'hBF00, 16'h3F80, 16'h0011, 16'h7FFF,
      16'h00FF, 16'h8001, 16'h3F01, 16'hBF01, 16'h4000, 16'hC0FF, 16'h01FF, 16'h8100};
    in_ch.valid = 0;
    in_ch.operand_a = 0;
    in_ch.operand_b = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_pair(16'h7F00, 16'hFF00, 0);
    send_pair(16'hFF00, 16'h7F00, 0);
    send_pair(16'h8000, 16'h8000, 0);
    send_pair(16'h3F80, 16'hBF80, 0);
    send_pair(16'h7EFF, 16'h7EFF, 0);
    send_pair(16'h0001, 16'h8002, 0);
    send_pair(16'h3F00, 16'h3301, 0);
    send_pair(16'h0100, 16'h8001, 0);
    for (int i = 0; i < 16; i++) send_pair(dir_ops[i], dir_ops[23 - i], 0);
    for (int i = 0; i < 750; i++) begin
      a = pick_operand();
      b = pick_operand();
      if ($urandom_range(3) == 0) b[14:8] = a[14:8] + 7'($urandom_range(12)) - 7'd6;
      if ($urandom_range(9) == 0) b = a ^ 16'h8000;
      send_pair(a, b, i >= 200);
    end
    in_ch.valid <= 0;
    send_done = 1;
  end

  initial begin
    @(posedge rst_n);
    repeat (40) @(posedge clk);
    long_hold <= 1;
    repeat (60) @(posedge clk);
    long_hold <= 0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else begin
      if (out_ch.valid && out_ch.ready) board.check_sum(out_ch.sum);
      if (long_hold) out_ch.ready <= 0;
      else if (board.checked < 150) out_ch.ready <= 1;
      else out_ch.ready <= ($urandom_range(99) < 70) || ($urandom_range(9) == 0);
    end
  end

  initial begin
    @(posedge send_done);
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d sums, including specials, subnormals and a long output stall.",
             board.checked);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end
endmodule
